// ===== hdl/vec3_fast_normalize_macros.svh =====
// Assertion macros for the vec3_fast_normalize checker.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef VEC3_FAST_NORMALIZE_MACROS_SVH
`define VEC3_FAST_NORMALIZE_MACROS_SVH

// Same-cycle implication.
`define VFN_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vfn check failed");

// Next-cycle implication.
`define VFN_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vfn check failed");

`endif

// ===== hdl/vfn_pkg.sv =====
// Package for vec3_fast_normalize: constants, types and binary32 arithmetic helpers.
// No dependencies.
package vfn_pkg;

    localparam int unsigned NumStages = 18;

    localparam logic [31:0] MAGIC_RSQRT = 32'h5f3759df;
    localparam logic [31:0] CANON_NAN   = 32'h7fc00000;
    localparam logic [31:0] FP_ONE_P5   = 32'h3fc00000;
    localparam logic [31:0] FP_HALF     = 32'h3f000000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_vec;

    // Operation between its first half (multiply or align/add) and rounding.
    // Value is m * 2^(ex - 127 - 49) unless spec is set.
    typedef struct packed {
        logic               spec;
        logic [31:0]        spec_val;
        logic               sign;
        logic signed [10:0] ex;
        logic [49:0]        m;
    } t_fp_mid;

    function automatic logic is_nan(input logic [31:0] a);
        is_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        is_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    endfunction

    function automatic t_fp_mid fp_mul_pre(input logic [31:0] a, input logic [31:0] b);
        t_fp_mid     r;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [47:0] prod;
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic        sg;
        logic        bad;
        sg  = a[31] ^ b[31];
        ma  = {a[30:23] != 8'd0, a[22:0]};
        mb  = {b[30:23] != 8'd0, b[22:0]};
        ea  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        bad = is_nan(a) || is_nan(b) || (is_inf(a) && (b[30:0] == 31'd0))
              || (is_inf(b) && (a[30:0] == 31'd0));
        prod = ma * mb;
        r.spec     = is_nan(a) || is_nan(b) || is_inf(a) || is_inf(b);
        r.spec_val = bad ? CANON_NAN : {sg, 8'hff, 23'd0};
        r.sign     = sg;
        r.ex       = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
        r.m        = {prod, 2'b00};
        fp_mul_pre = r;
    endfunction

    function automatic t_fp_mid fp_add_pre(input logic [31:0] a, input logic [31:0] b);
        t_fp_mid     r;
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  eb;
        logic [7:0]  es;
        logic [7:0]  d;
        logic [49:0] bigf;
        logic [49:0] smf;
        logic [49:0] al;
        logic [49:0] sum;
        logic        st;
        if (b[30:0] > a[30:0]) begin
            big = b;
            sml = a;
        end else begin
            big = a;
            sml = b;
        end
        eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d    = eb - es;
        bigf = {1'b0, big[30:23] != 8'd0, big[22:0], 25'd0};
        smf  = {1'b0, sml[30:23] != 8'd0, sml[22:0], 25'd0};
        if (d >= 8'd50) begin
            al = '0;
            st = (smf != '0);
        end else begin
            al = smf >> d;
            st = |(smf & ~({50{1'b1}} << d));
        end
        al[0] = al[0] | st;
        sum   = (a[31] ^ b[31]) ? (bigf - al) : (bigf + al);
        r.spec     = is_nan(a) || is_nan(b) || is_inf(a) || is_inf(b);
        r.spec_val = (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31])))
                     ? CANON_NAN : {big[31], 8'hff, 23'd0};
        r.sign     = (sum == '0) ? (a[31] & b[31]) : big[31];
        r.ex       = $signed({3'b000, eb}) + 11'sd1;
        r.m        = sum;
        fp_add_pre = r;
    endfunction

    // Normalize, pass special values, overflow to infinity, underflow to subnormal, round to nearest even.
    function automatic logic [31:0] fp_round(input t_fp_mid p);
        logic [5:0]         lz;
        logic               found;
        logic [49:0]        mn;
        logic signed [11:0] e;
        logic [11:0]        sh;
        logic               st;
        logic [7:0]         e8;
        logic               inc;
        logic [30:0]        mag;
        lz    = '0;
        found = 1'b0;
        for (int i = 49; i >= 0; i--) begin
            if (!found) begin
                if (p.m[i]) found = 1'b1;
                else        lz    = lz + 6'd1;
            end
        end
        mn = p.m << lz;
        e  = $signed({p.ex[10], p.ex}) - $signed({6'd0, lz});
        st = 1'b0;
        sh = '0;
        if (e < 12'sd1) begin
            sh = 12'(12'sd1 - e);
            if (sh >= 12'd50) begin
                st = (mn != '0);
                mn = '0;
            end else begin
                st = |(mn & ~({50{1'b1}} << sh));
                mn = mn >> sh;
            end
            e = 12'sd1;
        end
        e8  = mn[49] ? e[7:0] : 8'd0;
        st  = st | (|mn[24:0]);
        inc = mn[25] & (st | mn[26]);
        mag = {e8, mn[48:26]} + {30'd0, inc};
        if (p.spec)
            fp_round = p.spec_val;
        else if (p.m == '0)
            fp_round = {p.sign, 31'd0};
        else if (e > 12'sd254)
            fp_round = {p.sign, 8'hff, 23'd0};
        else
            fp_round = {p.sign, mag};
    endfunction

endpackage

// ===== hdl/vfn_in_if.sv =====
// Request channel of vec3_fast_normalize: valid/ready and three binary32 components.
// No dependencies.
interface vfn_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] in_x;
    logic [31:0] in_y;
    logic [31:0] in_z;

    modport source (output valid, output in_x, output in_y, output in_z, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

// ===== hdl/vfn_out_if.sv =====
// Result channel of vec3_fast_normalize: valid/ready, normalized vector and reciprocal length.
// No dependencies.
interface vfn_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [31:0] inv_length;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output inv_length, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input inv_length, output ready);
endinterface

// ===== hdl/vec3_fast_normalize.sv =====
// Top level of vec3_fast_normalize: 18-stage binary32 pipeline.
// Depends on vfn_pkg, vfn_in_if and vfn_out_if.
//
//   channel   dir   handshake        payload
//   i_req     in    valid / ready    in_x, in_y, in_z
//   o_rsp     out   valid / ready    out_x, out_y, out_z, inv_length
//
// One vector per cycle while o_rsp is ready. Each float op takes two stages
// (multiply or align/add, then normalize and round); nine ops are chained.
// Synchronous active-low reset clears the stage valid bits only.
// Each stage holds while it is full and the stage after it holds, so a stall
// on o_rsp fills bubbles first and i_req.ready drops only when all are full.
module vec3_fast_normalize (
    input  logic  i_clk,
    input  logic  i_rst_n,
    vfn_in_if.sink    i_req,
    vfn_out_if.source o_rsp
);
    import vfn_pkg::*;

    logic [NumStages:1] r_v;
    logic [NumStages:1] w_en;

    t_vec        r_xyz [1:16];
    logic [31:0] r_r0  [7:14];

    t_fp_mid r1_mx, r1_my, r1_mz;
    logic [31:0] r2_xx, r2_yy, r2_zz;
    t_fp_mid r3_add;
    logic [31:0] r3_zz;
    logic [31:0] r4_s01, r4_zz;
    t_fp_mid r5_add;
    logic [31:0] r6_s;
    t_fp_mid r7_mid;
    logic [31:0] r8_hs;
    t_fp_mid r9_mid;
    logic [31:0] r10_t1;
    t_fp_mid r11_mid;
    logic [31:0] r12_t2;
    t_fp_mid r13_mid;
    logic [31:0] r14_corr;
    t_fp_mid r15_mid;
    logic [31:0] r16_r;
    t_fp_mid r17_mx, r17_my, r17_mz;
    logic [31:0] r17_r;
    logic [31:0] r18_ox, r18_oy, r18_oz, r18_r;

    // Stage k advances when empty or when stage k+1 advances.
    always_comb begin
        w_en[NumStages] = !r_v[NumStages] || o_rsp.ready;
        for (int k = NumStages - 1; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k + 1];
        end
    end

    assign i_req.ready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) r_v[1] <= i_req.valid;
            for (int k = 2; k <= NumStages; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k - 1];
            end
        end
    end

    // Carry the input vector and the estimate alongside the arithmetic.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) r_xyz[1] <= '{x: i_req.in_x, y: i_req.in_y, z: i_req.in_z};
        for (int k = 2; k <= 16; k++) begin
            if (w_en[k]) r_xyz[k] <= r_xyz[k - 1];
        end
        if (w_en[7]) r_r0[7] <= MAGIC_RSQRT - {1'b0, r6_s[31:1]};
        for (int k = 8; k <= 14; k++) begin
            if (w_en[k]) r_r0[k] <= r_r0[k - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_mx <= fp_mul_pre(i_req.in_x, i_req.in_x);
            r1_my <= fp_mul_pre(i_req.in_y, i_req.in_y);
            r1_mz <= fp_mul_pre(i_req.in_z, i_req.in_z);
        end
        if (w_en[2]) begin
            r2_xx <= fp_round(r1_mx);
            r2_yy <= fp_round(r1_my);
            r2_zz <= fp_round(r1_mz);
        end
        if (w_en[3]) begin
            r3_add <= fp_add_pre(r2_xx, r2_yy);
            r3_zz  <= r2_zz;
        end
        if (w_en[4]) begin
            r4_s01 <= fp_round(r3_add);
            r4_zz  <= r3_zz;
        end
        if (w_en[5])  r5_add   <= fp_add_pre(r4_s01, r4_zz);
        if (w_en[6])  r6_s     <= fp_round(r5_add);
        if (w_en[7])  r7_mid   <= fp_mul_pre(r6_s, FP_HALF);
        if (w_en[8])  r8_hs    <= fp_round(r7_mid);
        if (w_en[9])  r9_mid   <= fp_mul_pre(r8_hs, r_r0[8]);
        if (w_en[10]) r10_t1   <= fp_round(r9_mid);
        if (w_en[11]) r11_mid  <= fp_mul_pre(r10_t1, r_r0[10]);
        if (w_en[12]) r12_t2   <= fp_round(r11_mid);
        // 1.5 - t2 as an add with the sign of t2 flipped
        if (w_en[13]) r13_mid  <= fp_add_pre(FP_ONE_P5, {~r12_t2[31], r12_t2[30:0]});
        if (w_en[14]) r14_corr <= fp_round(r13_mid);
        if (w_en[15]) r15_mid  <= fp_mul_pre(r_r0[14], r14_corr);
        if (w_en[16]) r16_r    <= fp_round(r15_mid);
        if (w_en[17]) begin
            r17_mx <= fp_mul_pre(r_xyz[16].x, r16_r);
            r17_my <= fp_mul_pre(r_xyz[16].y, r16_r);
            r17_mz <= fp_mul_pre(r_xyz[16].z, r16_r);
            r17_r  <= r16_r;
        end
        if (w_en[18]) begin
            r18_ox <= fp_round(r17_mx);
            r18_oy <= fp_round(r17_my);
            r18_oz <= fp_round(r17_mz);
            r18_r  <= r17_r;
        end
    end

    assign o_rsp.valid      = r_v[NumStages];
    assign o_rsp.out_x      = r18_ox;
    assign o_rsp.out_y      = r18_oy;
    assign o_rsp.out_z      = r18_oz;
    assign o_rsp.inv_length = r18_r;

endmodule

// ===== hdl/vfn_checker.sv =====
// Port-level checker for vec3_fast_normalize, bound to the top level.
// Depends on vfn_pkg and vec3_fast_normalize_macros.svh.
`include "vec3_fast_normalize_macros.svh"

module vfn_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_x,
    input logic [31:0] i_inv_length
);
    import vfn_pkg::*;

    logic w_x_ok;
    logic w_inv_ok;

    assign w_x_ok   = !is_nan(i_out_x) || (i_out_x == CANON_NAN);
    assign w_inv_ok = !is_nan(i_inv_length) || (i_inv_length == CANON_NAN);

    // hold a pending result until it is taken
    `VFN_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    // an empty output stage never blocks a new request
    `VFN_ASSERT_IMP(a_empty_accepts, !i_out_valid, i_in_ready)
    // reset drains the pipeline
    `VFN_ASSERT_IMP(a_reset_empty, $rose(i_rst_n), !i_out_valid)
    // a NaN on out_x or inv_length leaves as the canonical quiet NaN
    `VFN_ASSERT_IMP(a_nan_canon, i_out_valid, w_x_ok && w_inv_ok)

endmodule

bind vec3_fast_normalize vfn_port_checks u_vfn_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_x     (o_rsp.out_x),
    .i_inv_length(o_rsp.inv_length)
);
